>>> rtl/core/path_signature_level3_2d_assert.svh
// Assertion macros for the path signature block.
// Each macro expects clk and rst_n in scope.
`ifndef PATH_SIGNATURE_LEVEL3_2D_ASSERT_SVH
`define PATH_SIGNATURE_LEVEL3_2D_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define PSIG_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define PSIG_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Consequent holds after the antecedent, later than in PSIG_NEXT.
`define PSIG_AFTER2(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/core/psig_pkg.sv
package psig_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 12;
    localparam int OUT_BITS    = 48;

    // increment and level-1 width, 3*L1+d width, w = (3*L1+d)*d width
    localparam int D_W = SAMPLE_BITS + 1;
    localparam int U_W = SAMPLE_BITS + 4;
    localparam int W_W = 2 * SAMPLE_BITS + 5;

    // shared multiplier: one 24-bit chunk (plus sign) by a d or 6*d operand
    localparam int CH_W  = 24;
    localparam int MA_W  = CH_W + 1;
    localparam int MB_W  = SAMPLE_BITS + 4;
    localparam int P_W   = MA_W + MB_W;
    localparam int NCU   = (U_W + CH_W - 1) / CH_W;
    localparam int NCH2  = OUT_BITS / CH_W;
    localparam int NCW   = (W_W + CH_W - 1) / CH_W;
    localparam int NC3   = NCH2 + NCW;
    localparam int CNT_W = $clog2(NC3);
    localparam int EXT_W = ((NCW > NCH2) ? NCW : NCH2) * CH_W;

    localparam int ACC_A = OUT_BITS + MB_W;
    localparam int ACC_B = W_W + D_W;
    localparam int ACC_W = ((ACC_A > ACC_B) ? ACC_A : ACC_B) + 2;
    localparam int SUM_W = ACC_W + 1;

    // level-3 divide by 6*2^FRAC_BITS = shift by FRAC_BITS+1, then divide by 3
    localparam int DIV_SH = FRAC_BITS + 1;
    localparam int DIV_W  = ACC_W - DIV_SH;
    localparam int DIV_ST = (DIV_W + 7) / 8;
    localparam int DIV_PW = DIV_ST * 8;
    localparam int DSC_W  = $clog2(DIV_ST + 1);
    localparam int ROUND3 = 3 << FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic                          window_start;
        logic                          window_end;
    } point_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sig2_11;
        logic signed [OUT_BITS-1:0] sig2_12;
        logic signed [OUT_BITS-1:0] sig2_21;
        logic signed [OUT_BITS-1:0] sig2_22;
        logic signed [OUT_BITS-1:0] sig3_111;
        logic signed [OUT_BITS-1:0] sig3_112;
        logic signed [OUT_BITS-1:0] sig3_121;
        logic signed [OUT_BITS-1:0] sig3_122;
        logic signed [OUT_BITS-1:0] sig3_211;
        logic signed [OUT_BITS-1:0] sig3_212;
        logic signed [OUT_BITS-1:0] sig3_221;
        logic signed [OUT_BITS-1:0] sig3_222;
    } sig_t;

    typedef struct packed {
        logic                   go;
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
        logic [CNT_W-1:0]       sh;
    } mul_req_t;

    typedef struct packed {
        logic                  vld;
        logic signed [P_W-1:0] prod;
        logic [CNT_W-1:0]      sh;
    } mul_rsp_t;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] x;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] q;
    } div_rsp_t;

    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] vmax;
        logic signed [SUM_W-1:0] vmin;
        vmax = SUM_W'({(OUT_BITS-1){1'b1}});
        vmin = ~vmax;
        if (v > vmax)
        begin
            return vmax[OUT_BITS-1:0];
        end
        else if (v < vmin)
        begin
            return vmin[OUT_BITS-1:0];
        end
        return v[OUT_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/psig_mul.sv
module psig_mul
    import psig_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic signed [MA_W-1:0] a_s;
    logic signed [MB_W-1:0] b_s;
    logic signed [P_W-1:0]  prod_next;
    mul_rsp_t               rsp_reg;

    assign a_s       = req.a;
    assign b_s       = req.b;
    assign prod_next = P_W'(a_s) * P_W'(b_s);
    assign rsp       = rsp_reg;

    // one registered product per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_reg <= '0;
        end
        else
        begin
            rsp_reg.vld  <= req.go;
            rsp_reg.prod <= prod_next;
            rsp_reg.sh   <= req.sh;
        end
    end

endmodule

>>> rtl/core/psig_div3.sv
module psig_div3
    import psig_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_PW-1:0] xs_reg;
    logic [DIV_PW-1:0] q_reg;
    logic [1:0]        rem_reg;
    logic [1:0]        rem_next;
    logic [DSC_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [7:0]        qb_next;

    // restoring divide by three, eight quotient bits per cycle
    always_comb
    begin
        logic [2:0] r;
        logic [1:0] rm;
        logic [7:0] top;
        top = xs_reg[DIV_PW-1 -: 8];
        rm  = rem_reg;
        qb_next = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {rm, top[i]};
            if (r >= 3'd3)
            begin
                qb_next[i] = 1'b1;
                rm = 2'(r - 3'd3);
            end
            else
            begin
                rm = r[1:0];
            end
        end
        rem_next = rm;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg[DIV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xs_reg   <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                xs_reg  <= DIV_PW'(req.x);
                q_reg   <= '0;
                rem_reg <= '0;
                cnt_reg <= DSC_W'(DIV_ST);
            end
            else if (cnt_reg != '0)
            begin
                xs_reg   <= xs_reg << 8;
                q_reg    <= {q_reg[DIV_PW-9:0], qb_next};
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == DSC_W'(1));
            end
        end
    end

endmodule

>>> rtl/core/path_signature_level3_2d.sv
// Truncated level-3 signature of a 2-D piecewise-linear path.
// Input channel (point, point_valid, point_stall): one path point per request,
// signed Q3.12 coordinates plus window_start / window_end flags.
// Output channel (sig, sig_valid, sig_stall): one request of 4 level-2 and
// 8 level-3 terms, signed Q23.24 saturated, for each point with window_end.
// A window_start point, or the first point after reset, becomes the base and
// clears all sums; with window_end also set it emits all zeros.
// Every other point holds point_stall high until its update is done, and with
// window_end until its result is in the output register, so no new point is
// taken while one is in work: each product goes through one shared 25x20
// multiplier in 24-bit chunks (4 cross terms, 8 level-3 updates of four chunks
// each, 4 level-2 updates), and each level-3 update waits on the iterative
// divide-by-three unit.
// Results land in an output register, so the next point is accepted while a
// result waits; a stalled result holds valid and data until taken, and the
// block holds a finished point until the output register is free.
// Reset clears all sums and forgets the base.
module path_signature_level3_2d
    import psig_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  point_t point,
    input  logic   point_valid,
    output logic   point_stall,
    output sig_t   sig,
    output logic   sig_valid,
    input  logic   sig_stall
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DRAIN, S_POST, S_DIV, S_FIN, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        JOB_W, JOB_3, JOB_2
    } job_t;

    state_t                        state_reg;
    job_t                          job_reg;
    logic [2:0]                    term_reg;
    logic [CNT_W-1:0]              k_reg;
    logic                          base_reg;
    logic                          end_reg;
    logic                          neg_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg [2];
    logic signed [SAMPLE_BITS-1:0] px_reg   [2];
    logic signed [D_W-1:0]         d_reg    [2];
    logic signed [D_W-1:0]         l1_reg   [2];
    logic signed [OUT_BITS-1:0]    l2_reg   [4];
    logic signed [OUT_BITS-1:0]    l3_reg   [8];
    logic signed [W_W-1:0]         w_reg    [4];
    logic signed [ACC_W-1:0]       acc_reg;
    sig_t                          sig_reg;
    logic                          sig_valid_reg;

    logic                    accept;
    logic                    a_i, b_i, c_i;
    logic [1:0]              ab;
    logic signed [U_W-1:0]   u_val, v_val;
    logic signed [MB_W-1:0]  d6;
    logic signed [EXT_W-1:0] ext;
    logic signed [MB_W-1:0]  bsel;
    logic [CNT_W-1:0]        kk, topc, k_last;
    logic [CH_W-1:0]         chunk;
    mul_req_t                mreq;
    mul_rsp_t                mrsp;
    div_req_t                dreq;
    div_rsp_t                drsp;
    logic signed [P_W-1:0]   prod_s;
    logic signed [ACC_W-1:0] prod_ext, acc_sum;
    logic                    neg;
    logic [ACC_W-1:0]        mag, m3, m2;
    logic [ACC_W-2:0]        q2;
    logic signed [SUM_W-1:0] q2s, q3s, sum2, sum3;
    logic signed [OUT_BITS-1:0] n2, n3;

    assign accept      = point_valid && !point_stall;
    assign point_stall = (state_reg != S_IDLE);
    assign sig         = sig_reg;
    assign sig_valid   = sig_valid_reg;

    // term index: level-3 uses a,b,c; cross terms and level-2 use a,b
    assign a_i = (job_reg == JOB_3) ? term_reg[2] : term_reg[1];
    assign b_i = (job_reg == JOB_3) ? term_reg[1] : term_reg[0];
    assign c_i = term_reg[0];
    assign ab  = {a_i, b_i};

    assign u_val = (U_W'(l1_reg[a_i]) <<< 1) + U_W'(l1_reg[a_i]) + U_W'(d_reg[a_i]);
    assign v_val = (U_W'(l1_reg[a_i]) <<< 1) + U_W'(d_reg[a_i]);
    assign d6    = (MB_W'(d_reg[c_i]) <<< 2) + (MB_W'(d_reg[c_i]) <<< 1);

    assign k_last = (job_reg == JOB_3) ? CNT_W'(NC3 - 1) : CNT_W'(NCU - 1);

    // pick the operand and chunk for this multiplier issue
    always_comb
    begin
        ext  = EXT_W'(u_val);
        bsel = MB_W'(d_reg[b_i]);
        kk   = k_reg;
        topc = CNT_W'(NCU - 1);
        case (job_reg)
            JOB_W:
            begin
                ext  = EXT_W'(u_val);
                bsel = MB_W'(d_reg[b_i]);
            end
            JOB_3:
            begin
                if (k_reg < CNT_W'(NCH2))
                begin
                    ext  = EXT_W'(l2_reg[ab]);
                    bsel = d6;
                    topc = CNT_W'(NCH2 - 1);
                end
                else
                begin
                    ext  = EXT_W'(w_reg[ab]);
                    bsel = MB_W'(d_reg[c_i]);
                    kk   = k_reg - CNT_W'(NCH2);
                    topc = CNT_W'(NCW - 1);
                end
            end
            JOB_2:
            begin
                ext  = EXT_W'(v_val);
                bsel = MB_W'(d_reg[b_i]);
            end
            default:
            begin
                ext  = EXT_W'(u_val);
                bsel = MB_W'(d_reg[b_i]);
            end
        endcase
    end

    assign chunk   = ext[kk*CH_W +: CH_W];
    assign mreq.go = (state_reg == S_MUL);
    assign mreq.a  = (kk == topc) ? {chunk[CH_W-1], chunk} : {1'b0, chunk};
    assign mreq.b  = bsel;
    assign mreq.sh = kk;

    psig_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // weight each chunk product and add it in
    assign prod_s   = mrsp.prod;
    assign prod_ext = ACC_W'(prod_s) <<< (CH_W * mrsp.sh);
    assign acc_sum  = acc_reg + (mrsp.vld ? prod_ext : '0);

    // round to nearest, ties away from zero, on the magnitude
    assign neg = acc_reg[ACC_W-1];
    assign mag = neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign m3  = mag + ACC_W'(ROUND3);
    assign m2  = mag + ACC_W'(1);
    assign q2  = m2[ACC_W-1:1];

    assign dreq.go = (state_reg == S_POST) && (job_reg == JOB_3);
    assign dreq.x  = m3[ACC_W-1:DIV_SH];

    psig_div3 u_div3 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign q2s  = neg ? -SUM_W'(q2) : SUM_W'(q2);
    assign sum2 = q2s + SUM_W'(l2_reg[ab]);
    assign n2   = sat_out(sum2);
    assign q3s  = neg_reg ? -SUM_W'(drsp.q) : SUM_W'(drsp.q);
    assign sum3 = q3s + SUM_W'(l3_reg[term_reg]);
    assign n3   = sat_out(sum3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= JOB_W;
            term_reg      <= '0;
            k_reg         <= '0;
            base_reg      <= 1'b0;
            end_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            sig_reg       <= '0;
            sig_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                prev_reg[i] <= '0;
                px_reg[i]   <= '0;
                d_reg[i]    <= '0;
                l1_reg[i]   <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                l2_reg[i] <= '0;
                w_reg[i]  <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                l3_reg[i] <= '0;
            end
        end
        else
        begin
            acc_reg <= acc_sum;
            // drop the result once the receiver takes it
            if (sig_valid_reg && !sig_stall)
            begin
                sig_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        px_reg[0] <= point.x1;
                        px_reg[1] <= point.x2;
                        end_reg   <= point.window_end;
                        if (point.window_start || !base_reg)
                        begin
                            // new base: clear the sums
                            base_reg    <= 1'b1;
                            prev_reg[0] <= point.x1;
                            prev_reg[1] <= point.x2;
                            for (int i = 0; i < 2; i++)
                            begin
                                l1_reg[i] <= '0;
                            end
                            for (int i = 0; i < 4; i++)
                            begin
                                l2_reg[i] <= '0;
                            end
                            for (int i = 0; i < 8; i++)
                            begin
                                l3_reg[i] <= '0;
                            end
                            state_reg <= point.window_end ? S_OUT : S_IDLE;
                        end
                        else
                        begin
                            d_reg[0]  <= D_W'(point.x1) - D_W'(prev_reg[0]);
                            d_reg[1]  <= D_W'(point.x2) - D_W'(prev_reg[1]);
                            job_reg   <= JOB_W;
                            term_reg  <= '0;
                            k_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    if (k_reg == k_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_POST;
                end
                S_POST:
                begin
                    acc_reg <= '0;
                    case (job_reg)
                        JOB_W:
                        begin
                            w_reg[ab] <= acc_reg[W_W-1:0];
                            state_reg <= S_MUL;
                            if (term_reg == 3'd3)
                            begin
                                job_reg  <= JOB_3;
                                term_reg <= '0;
                            end
                            else
                            begin
                                term_reg <= term_reg + 1'b1;
                            end
                        end
                        JOB_3:
                        begin
                            neg_reg   <= neg;
                            state_reg <= S_DIV;
                        end
                        JOB_2:
                        begin
                            l2_reg[ab] <= n2;
                            if (term_reg == 3'd3)
                            begin
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                term_reg  <= term_reg + 1'b1;
                                state_reg <= S_MUL;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        l3_reg[term_reg] <= n3;
                        state_reg        <= S_MUL;
                        if (term_reg == 3'd7)
                        begin
                            job_reg  <= JOB_2;
                            term_reg <= '0;
                        end
                        else
                        begin
                            term_reg <= term_reg + 1'b1;
                        end
                    end
                end
                S_FIN:
                begin
                    // advance level 1 and the previous point
                    for (int i = 0; i < 2; i++)
                    begin
                        l1_reg[i]   <= l1_reg[i] + d_reg[i];
                        prev_reg[i] <= px_reg[i];
                    end
                    state_reg <= end_reg ? S_OUT : S_IDLE;
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (!sig_valid_reg || !sig_stall)
                    begin
                        sig_reg.sig2_11  <= l2_reg[0];
                        sig_reg.sig2_12  <= l2_reg[1];
                        sig_reg.sig2_21  <= l2_reg[2];
                        sig_reg.sig2_22  <= l2_reg[3];
                        sig_reg.sig3_111 <= l3_reg[0];
                        sig_reg.sig3_112 <= l3_reg[1];
                        sig_reg.sig3_121 <= l3_reg[2];
                        sig_reg.sig3_122 <= l3_reg[3];
                        sig_reg.sig3_211 <= l3_reg[4];
                        sig_reg.sig3_212 <= l3_reg[5];
                        sig_reg.sig3_221 <= l3_reg[6];
                        sig_reg.sig3_222 <= l3_reg[7];
                        sig_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/psig_checker.sv
`include "path_signature_level3_2d_assert.svh"

module psig_checker
    import psig_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input point_t point,
    input logic   point_valid,
    input logic   point_stall,
    input sig_t   sig,
    input logic   sig_valid,
    input logic   sig_stall
);

    // a stalled result keeps its request
    `PSIG_NEXT(a_sig_hold, sig_valid && sig_stall, sig_valid)
    `PSIG_NEXT(a_sig_stable, sig_valid && sig_stall, $stable(sig))
    // a point without window_end never raises a result right after it
    `PSIG_NEXT(a_no_spurious, point_valid && !point_stall && !point.window_end, !$rose(sig_valid))
    // start and end together emit an all-zero signature
    `PSIG_AFTER2(a_zero_window, point_valid && !point_stall && point.window_start && point.window_end && !sig_valid, sig_valid && (sig == '0))

endmodule

bind path_signature_level3_2d psig_checker u_psig_checker (.*);

>>> bench/tb_top.sv
module tb_top;
    import psig_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  TAIL_CYCLES = 400;
    localparam int  NUM_TERMS   = 12;

    // One pending request for the driver; hold_for_drain makes the driver
    // wait until every expected signature has come back before sending it.
    typedef struct {
        point_t pt;
        bit     hold_for_drain;
    } pending_point_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    point_t point = '0;
    logic   point_valid = 1'b0;
    logic   point_stall;
    sig_t   sig;
    logic   sig_valid;
    logic   sig_stall = 1'b0;

    pending_point_t point_queue[$];
    sig_t           sig_expected[$];

    // Predictor state, kept wide enough that no update wraps.
    logic signed [63:0] prev_pt[2];
    logic signed [63:0] lvl1[2];
    logic signed [63:0] lvl2[4];
    logic signed [63:0] lvl3[8];
    bit                 have_base;

    int  cycle_count = 0;
    int  errors = 0;
    int  points_sent = 0;
    int  sigs_checked = 0;
    int  saturated_terms = 0;
    bit  stimulus_done = 1'b0;
    bit  quiet_mode = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  long_hold = 0;
    bit  long_hold_done = 1'b0;

    path_signature_level3_2d i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point       (point),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .sig         (sig),
        .sig_valid   (sig_valid),
        .sig_stall   (sig_stall)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Divide by a positive constant, rounding to nearest with ties away
    // from zero.
    function automatic logic signed [127:0] div_round_away(
        input logic signed [127:0] v, input logic signed [127:0] dv);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (v < 0) ? -v : v;
        q = (mag + dv / 2) / dv;
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic signed [63:0] clamp48(input logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (OUT_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi[63:0];
        end
        else if (v < lo)
        begin
            return lo[63:0];
        end
        return v[63:0];
    endfunction

    function automatic int gap_length();
        int r;
        if (quiet_mode)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Advance the signature state by one accepted point; queue the
    // expected terms when the point closes a window.
    task automatic advance_signature(input point_t pt);
        logic signed [63:0]  p[2];
        logic signed [63:0]  d[2];
        logic signed [63:0]  n2[4];
        logic signed [63:0]  n3[8];
        logic signed [127:0] t;
        logic [NUM_TERMS*OUT_BITS-1:0] flat;
        p[0] = 64'(pt.x1);
        p[1] = 64'(pt.x2);
        if (pt.window_start || !have_base)
        begin
            // Take this point as the base and clear every sum.
            for (int i = 0; i < 2; i++) lvl1[i] = 0;
            for (int i = 0; i < 4; i++) lvl2[i] = 0;
            for (int i = 0; i < 8; i++) lvl3[i] = 0;
            have_base = 1'b1;
        end
        else
        begin
            d[0] = p[0] - prev_pt[0];
            d[1] = p[1] - prev_pt[1];
            for (int a = 0; a < 2; a++)
                for (int b = 0; b < 2; b++)
                    for (int c = 0; c < 2; c++)
                    begin
                        t = 128'(6 * lvl2[a*2+b]) * 128'(d[c])
                          + 128'(3 * lvl1[a]) * 128'(d[b]) * 128'(d[c])
                          + 128'(d[a]) * 128'(d[b]) * 128'(d[c]);
                        t = div_round_away(t, 128'sd6 <<< FRAC_BITS);
                        n3[a*4+b*2+c] = clamp48(t + 128'(lvl3[a*4+b*2+c]));
                    end
            for (int a = 0; a < 2; a++)
                for (int b = 0; b < 2; b++)
                begin
                    t = 128'(2 * lvl1[a] + d[a]) * 128'(d[b]);
                    t = div_round_away(t, 128'sd2);
                    n2[a*2+b] = clamp48(t + 128'(lvl2[a*2+b]));
                end
            for (int i = 0; i < 4; i++) lvl2[i] = n2[i];
            for (int i = 0; i < 8; i++) lvl3[i] = n3[i];
            lvl1[0] = lvl1[0] + d[0];
            lvl1[1] = lvl1[1] + d[1];
        end
        prev_pt[0] = p[0];
        prev_pt[1] = p[1];
        if (pt.window_end)
        begin
            for (int k = 0; k < 4; k++)
                flat[(NUM_TERMS-k)*OUT_BITS-1 -: OUT_BITS] = lvl2[k][OUT_BITS-1:0];
            for (int k = 0; k < 8; k++)
                flat[(NUM_TERMS-4-k)*OUT_BITS-1 -: OUT_BITS] = lvl3[k][OUT_BITS-1:0];
            sig_expected.push_back(sig_t'(flat));
        end
    endtask

    task automatic add_point(input int x1, input int x2, input bit ws, input bit we);
        pending_point_t pp;
        pp.pt.x1 = x1[15:0];
        pp.pt.x2 = x2[15:0];
        pp.pt.window_start = ws;
        pp.pt.window_end = we;
        pp.hold_for_drain = 1'b0;
        point_queue.push_back(pp);
    endtask

    // Driver: hold a stalled request, otherwise pop the next one after a gap.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (point_valid && !point_stall)
            begin
                advance_signature(point);
                points_sent <= points_sent + 1;
            end
            if (!point_valid || !point_stall)
            begin
                if (send_gap > 0)
                begin
                    point_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (point_queue.size() > 0 &&
                         point_queue[0].hold_for_drain &&
                         (sig_expected.size() > 0 ||
                          (point_valid && point.window_end)))
                begin
                    // Pause the sender until every result is back.
                    point_valid <= 1'b0;
                end
                else if (point_queue.size() > 0)
                begin
                    point <= point_queue[0].pt;
                    point_valid <= 1'b1;
                    void'(point_queue.pop_front());
                    send_gap <= gap_length();
                end
                else
                begin
                    point_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once results flow.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold > 0)
            begin
                sig_stall <= 1'b1;
                long_hold <= long_hold - 1;
            end
            else if (!long_hold_done && sigs_checked == 30)
            begin
                sig_stall <= 1'b1;
                long_hold <= 1500;
                long_hold_done <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                sig_stall <= 1'b1;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                sig_stall <= 1'b0;
                recv_gap <= gap_length();
            end
        end
    end

    // Monitor: compare each accepted signature with the oldest expectation.
    always @(posedge clk)
    begin
        sig_t exp_sig;
        logic [NUM_TERMS*OUT_BITS-1:0] e_flat;
        logic [NUM_TERMS*OUT_BITS-1:0] a_flat;
        logic signed [OUT_BITS-1:0] ev;
        logic signed [OUT_BITS-1:0] av;
        string names[NUM_TERMS];
        names = '{"sig2_11", "sig2_12", "sig2_21", "sig2_22",
                  "sig3_111", "sig3_112", "sig3_121", "sig3_122",
                  "sig3_211", "sig3_212", "sig3_221", "sig3_222"};
        if (rst_n && sig_valid && !sig_stall)
        begin
            if (sig_expected.size() == 0)
            begin
                $error("signature request with no expectation waiting");
                errors = errors + 1;
            end
            else
            begin
                exp_sig = sig_expected.pop_front();
                e_flat = exp_sig;
                a_flat = sig;
                for (int k = 0; k < NUM_TERMS; k++)
                begin
                    ev = e_flat[(NUM_TERMS-k)*OUT_BITS-1 -: OUT_BITS];
                    av = a_flat[(NUM_TERMS-k)*OUT_BITS-1 -: OUT_BITS];
                    if (ev === {1'b0, {(OUT_BITS-1){1'b1}}} ||
                        ev === {1'b1, {(OUT_BITS-1){1'b0}}})
                        saturated_terms = saturated_terms + 1;
                    if (av !== ev)
                    begin
                        $error("%s expected %0d got %0d", names[k], ev, av);
                        errors = errors + 1;
                    end
                end
            end
            sigs_checked <= sigs_checked + 1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    // Toggle stretches with no idling at all.
    always @(posedge clk)
    begin
        if (cycle_count % 700 == 0)
            quiet_mode <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        pending_point_t pp;
        int n;
        int amp;
        for (int i = 0; i < 2; i++)
        begin
            prev_pt[i] = 0;
            lvl1[i] = 0;
        end
        for (int i = 0; i < 4; i++) lvl2[i] = 0;
        for (int i = 0; i < 8; i++) lvl3[i] = 0;
        have_base = 1'b0;

        // Directed: first point after reset is the base even without start.
        add_point(100, -200, 0, 0);
        add_point(32767, 32767, 0, 1);
        // Start and end together emit zeros.
        add_point(-32768, 32767, 1, 1);
        // Full-scale jumps between the corners.
        add_point(-32768, -32768, 1, 0);
        add_point(32767, 32767, 0, 0);
        add_point(-32768, 32767, 0, 0);
        add_point(32767, -32768, 0, 1);
        // Extend the same window after an emission.
        add_point(0, 0, 0, 1);
        add_point(-32768, -32768, 0, 1);
        // Zero-length segments and single-bit steps.
        add_point(5, 5, 1, 0);
        add_point(5, 5, 0, 0);
        add_point(6, 4, 0, 1);
        add_point(-1, -1, 0, 1);
        add_point(0, 0, 1, 1);

        // Drain before the random part: sender pauses until results are in.
        pp.pt = '0;
        pp.pt.window_start = 1'b1;
        pp.pt.window_end = 1'b1;
        pp.hold_for_drain = 1'b1;
        point_queue.push_back(pp);

        // Long full-scale loops to drive the level-3 terms toward saturation.
        add_point(-32768, -32768, 1, 0);
        for (int i = 0; i < 60; i++)
        begin
            add_point(32767, -32768, 0, 0);
            add_point(32767, 32767, 0, 0);
            add_point(-32768, 32767, 0, 0);
            add_point(-32768, -32768, 0, (i % 15 == 14));
        end

        // Random windows: mostly well-formed with random content, some noise.
        while (point_queue.size() < 1950)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: points with random flags.
                add_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 6);
                amp = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(0, 4095);
                add_point($urandom_range(0, 65535), $urandom_range(0, 65535), 1, 0);
                for (int i = 0; i < n; i++)
                begin
                    if (amp == 65535)
                        add_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                                  0, (i == n - 1) || ($urandom_range(0, 7) == 0));
                    else
                        add_point($urandom_range(0, amp) - amp / 2,
                                  $urandom_range(0, amp) - amp / 2,
                                  0, (i == n - 1) || ($urandom_range(0, 7) == 0));
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (point_queue.size() == 0 && !point_valid);
        wait (sig_expected.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sig_expected.size() != 0)
        begin
            $error("%0d signatures never arrived", sig_expected.size());
            errors = errors + 1;
        end
        $display("sent %0d points, checked %0d signatures (%0d saturated terms)",
                 points_sent, sigs_checked, saturated_terms);
        $display("covered base without start, start with end, full-scale loops, stalls");
        if (errors == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
